FILE: rtl/core/jsce_pkg.sv
// shared types, command codes and helper functions for the jtag shift command engine
// no dependencies
package jsce_pkg;

  // host command codes
  localparam logic [7:0] CMD_SET_LOW      = 8'h80;
  localparam logic [7:0] CMD_GET_LOW      = 8'h81;
  localparam logic [7:0] CMD_SET_HIGH     = 8'h82;
  localparam logic [7:0] CMD_GET_HIGH     = 8'h83;
  localparam logic [7:0] CMD_LOOP_ON      = 8'h84;
  localparam logic [7:0] CMD_LOOP_OFF     = 8'h85;
  localparam logic [7:0] CMD_SET_DIVISOR  = 8'h86;
  localparam logic [7:0] CMD_FLUSH        = 8'h87;
  localparam logic [7:0] CMD_BYTE_LSB_A   = 8'h19;
  localparam logic [7:0] CMD_BYTE_LSB_B   = 8'h1d;
  localparam logic [7:0] CMD_BYTE_LSB_RA  = 8'h39;
  localparam logic [7:0] CMD_BYTE_LSB_RB  = 8'h3d;
  localparam logic [7:0] CMD_BYTE_MSB_A   = 8'h11;
  localparam logic [7:0] CMD_BYTE_MSB_B   = 8'h15;
  localparam logic [7:0] CMD_BYTE_MSB_RA  = 8'h31;
  localparam logic [7:0] CMD_BYTE_MSB_RB  = 8'h35;
  localparam logic [7:0] CMD_BIT_LSB_A    = 8'h1b;
  localparam logic [7:0] CMD_BIT_LSB_B    = 8'h1f;
  localparam logic [7:0] CMD_BIT_LSB_RA   = 8'h3b;
  localparam logic [7:0] CMD_BIT_LSB_RB   = 8'h3f;
  localparam logic [7:0] CMD_BIT_MSB_A    = 8'h13;
  localparam logic [7:0] CMD_BIT_MSB_B    = 8'h17;
  localparam logic [7:0] CMD_TMS_A        = 8'h4b;
  localparam logic [7:0] CMD_TMS_B        = 8'h4f;
  localparam logic [7:0] CMD_TMS_RA       = 8'h6b;
  localparam logic [7:0] CMD_TMS_RB       = 8'h6f;

  localparam logic [7:0] ERR_MARK     = 8'hFA;
  localparam logic [7:0] REPLY_OFFSET = 8'h80;

  typedef enum logic [2:0] {
    OP_REPLY    = 3'd0,
    OP_ERROR    = 3'd1,
    OP_BYTE_LSB = 3'd2,
    OP_BYTE_MSB = 3'd3,
    OP_BIT_LSB  = 3'd4,
    OP_BIT_MSB  = 3'd5,
    OP_TMS      = 3'd6
  } op_kind_e;

  // one classified operation handed from front to back
  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  data;
    logic [7:0]  tdo;
    logic [3:0]  nclk;
    logic        rd;
    logic        hold;
  } op_t;

  localparam int unsigned OpW = $bits(op_t);

  typedef struct packed {
    logic [3:0] clock_count;
    logic [7:0] tdi_levels;
    logic [7:0] tms_levels;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       last;
  } result_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [8:0] m;
    m = (9'd1 << n) - 9'd1;
    return m[7:0];
  endfunction

endpackage

FILE: rtl/core/jsce_fifo.sv
// small register queue between the command front and the shift back
// no dependencies
module jsce_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/core/jsce_front.sv
// command front: parses the host byte stream and classifies bytes into operations
// depends on jsce_pkg
module jsce_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      stream_byte_i,
  input  logic [7:0]      tdo_samples_i,
  output logic            push_o,
  output jsce_pkg::op_t   op_o
);

  typedef enum logic [10:0] {
    M_IDLE     = 11'b000_0000_0001,
    M_LEN_LO   = 11'b000_0000_0010,
    M_LEN_HI   = 11'b000_0000_0100,
    M_BYTE_LSB = 11'b000_0000_1000,
    M_BYTE_MSB = 11'b000_0001_0000,
    M_BIT_LEN  = 11'b000_0010_0000,
    M_BIT_LSB  = 11'b000_0100_0000,
    M_BIT_MSB  = 11'b000_1000_0000,
    M_TMS      = 11'b001_0000_0000,
    M_SKIP_1   = 11'b010_0000_0000,
    M_SKIP_2   = 11'b100_0000_0000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  bits_q, bits_d;
  logic        hold_q, hold_d;
  logic [2:0]  nm1;
  logic [3:0]  nclk;
  logic [7:0]  b;

  assign b    = stream_byte_i;
  assign nm1  = (bits_q > 8'd7) ? 3'd7 : bits_q[2:0];
  assign nclk = {1'b0, nm1} + 4'd1;

  always_comb begin
    mode_d       = mode_q;
    cmd_d        = cmd_q;
    left_d       = left_q;
    bits_d       = bits_q;
    hold_d       = hold_q;
    push_o       = 1'b0;
    op_o.kind    = jsce_pkg::OP_REPLY;
    op_o.data    = b;
    op_o.tdo     = tdo_samples_i;
    op_o.nclk    = nclk;
    op_o.rd      = 1'b0;
    op_o.hold    = hold_q;
    if (accept_i) begin
      unique case (mode_q)
        M_IDLE: begin
          cmd_d = b;
          unique case (b)
            jsce_pkg::CMD_SET_LOW, jsce_pkg::CMD_SET_HIGH, jsce_pkg::CMD_SET_DIVISOR: begin
              mode_d = M_SKIP_1;
            end
            jsce_pkg::CMD_GET_LOW, jsce_pkg::CMD_GET_HIGH: begin
              push_o    = 1'b1;
              op_o.kind = jsce_pkg::OP_REPLY;
              op_o.data = b - jsce_pkg::REPLY_OFFSET;
            end
            jsce_pkg::CMD_LOOP_ON, jsce_pkg::CMD_LOOP_OFF, jsce_pkg::CMD_FLUSH: begin
              mode_d = M_IDLE;
            end
            jsce_pkg::CMD_BYTE_LSB_A, jsce_pkg::CMD_BYTE_LSB_B,
            jsce_pkg::CMD_BYTE_LSB_RA, jsce_pkg::CMD_BYTE_LSB_RB,
            jsce_pkg::CMD_BYTE_MSB_A, jsce_pkg::CMD_BYTE_MSB_B,
            jsce_pkg::CMD_BYTE_MSB_RA, jsce_pkg::CMD_BYTE_MSB_RB: begin
              mode_d = M_LEN_LO;
            end
            jsce_pkg::CMD_TMS_A, jsce_pkg::CMD_TMS_B,
            jsce_pkg::CMD_TMS_RA, jsce_pkg::CMD_TMS_RB,
            jsce_pkg::CMD_BIT_LSB_A, jsce_pkg::CMD_BIT_LSB_B,
            jsce_pkg::CMD_BIT_LSB_RA, jsce_pkg::CMD_BIT_LSB_RB,
            jsce_pkg::CMD_BIT_MSB_A, jsce_pkg::CMD_BIT_MSB_B: begin
              mode_d = M_BIT_LEN;
            end
            default: begin
              push_o    = 1'b1;
              op_o.kind = jsce_pkg::OP_ERROR;
            end
          endcase
        end
        M_LEN_LO: begin
          left_d = {8'd0, b};
          mode_d = M_LEN_HI;
        end
        M_LEN_HI: begin
          left_d = {b, left_q[7:0]};
          if (cmd_q == jsce_pkg::CMD_BYTE_MSB_A || cmd_q == jsce_pkg::CMD_BYTE_MSB_B ||
              cmd_q == jsce_pkg::CMD_BYTE_MSB_RA || cmd_q == jsce_pkg::CMD_BYTE_MSB_RB) begin
            mode_d = M_BYTE_MSB;
          end else begin
            mode_d = M_BYTE_LSB;
          end
        end
        M_BYTE_LSB: begin
          push_o    = 1'b1;
          op_o.kind = jsce_pkg::OP_BYTE_LSB;
          op_o.rd   = (cmd_q == jsce_pkg::CMD_BYTE_LSB_RA || cmd_q == jsce_pkg::CMD_BYTE_LSB_RB);
          if (left_q == '0) begin
            mode_d = M_IDLE;
          end
          left_d = left_q - 16'd1;
        end
        M_BYTE_MSB: begin
          push_o    = 1'b1;
          op_o.kind = jsce_pkg::OP_BYTE_MSB;
          op_o.rd   = (cmd_q == jsce_pkg::CMD_BYTE_MSB_RA || cmd_q == jsce_pkg::CMD_BYTE_MSB_RB);
          if (left_q == '0) begin
            mode_d = M_IDLE;
          end
          left_d = left_q - 16'd1;
        end
        M_BIT_LEN: begin
          bits_d = b;
          if (cmd_q == jsce_pkg::CMD_TMS_A || cmd_q == jsce_pkg::CMD_TMS_B ||
              cmd_q == jsce_pkg::CMD_TMS_RA || cmd_q == jsce_pkg::CMD_TMS_RB) begin
            mode_d = M_TMS;
          end else if (cmd_q == jsce_pkg::CMD_BIT_MSB_A || cmd_q == jsce_pkg::CMD_BIT_MSB_B) begin
            mode_d = M_BIT_MSB;
          end else begin
            mode_d = M_BIT_LSB;
          end
        end
        M_BIT_LSB: begin
          push_o    = 1'b1;
          op_o.kind = jsce_pkg::OP_BIT_LSB;
          op_o.rd   = (cmd_q == jsce_pkg::CMD_BIT_LSB_RA || cmd_q == jsce_pkg::CMD_BIT_LSB_RB);
          mode_d    = M_IDLE;
        end
        M_BIT_MSB: begin
          push_o    = 1'b1;
          op_o.kind = jsce_pkg::OP_BIT_MSB;
          mode_d    = M_IDLE;
        end
        M_TMS: begin
          push_o    = 1'b1;
          op_o.kind = jsce_pkg::OP_TMS;
          op_o.rd   = (cmd_q == jsce_pkg::CMD_TMS_RA || cmd_q == jsce_pkg::CMD_TMS_RB);
          hold_d    = b[nm1];
          mode_d    = M_IDLE;
        end
        M_SKIP_1: begin
          mode_d = M_SKIP_2;
        end
        M_SKIP_2: begin
          mode_d = M_IDLE;
        end
        default: begin
          mode_d = M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cmd_q  <= '0;
      left_q <= '0;
      bits_q <= '0;
      hold_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      cmd_q  <= cmd_d;
      left_q <= left_d;
      bits_q <= bits_d;
      hold_q <= hold_d;
    end
  end

endmodule

FILE: rtl/core/jsce_back.sv
// shift back end: turns queued operations into tck, tdi, tms and reply results
// depends on jsce_pkg
module jsce_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  input  jsce_pkg::op_t      op_i,
  output logic               op_pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output jsce_pkg::result_t  res_o
);

  jsce_pkg::result_t res_q, res_d, calc;
  logic              valid_q, valid_d;
  logic              echo_q, echo_d;
  logic [7:0]        echo_byte_q, echo_byte_d;
  logic              load;
  logic [7:0]        mask, hold8, low_reply;

  assign mask      = jsce_pkg::low_mask(op_i.nclk);
  assign hold8     = op_i.hold ? 8'hFF : 8'h00;
  assign low_reply = 8'((op_i.tdo & mask) << (4'd8 - op_i.nclk));
  assign load      = !valid_q || res_ready_i;
  assign op_pop_o  = load && !echo_q && op_valid_i;

  always_comb begin
    calc             = '0;
    calc.last        = 1'b1;
    calc.reply_valid = op_i.rd;
    unique case (op_i.kind)
      jsce_pkg::OP_REPLY: begin
        calc.reply_valid = 1'b1;
        calc.reply_byte  = op_i.data;
      end
      jsce_pkg::OP_ERROR: begin
        calc.reply_valid = 1'b1;
        calc.reply_byte  = jsce_pkg::ERR_MARK;
        calc.last        = 1'b0;
      end
      jsce_pkg::OP_BYTE_LSB: begin
        calc.clock_count = 4'd8;
        calc.tdi_levels  = op_i.data;
        calc.tms_levels  = hold8;
        calc.reply_byte  = op_i.rd ? op_i.tdo : 8'd0;
      end
      jsce_pkg::OP_BYTE_MSB: begin
        calc.clock_count = 4'd8;
        calc.tdi_levels  = jsce_pkg::rev8(op_i.data);
        calc.tms_levels  = hold8;
        calc.reply_byte  = op_i.rd ? jsce_pkg::rev8(op_i.tdo) : 8'd0;
      end
      jsce_pkg::OP_BIT_LSB: begin
        calc.clock_count = op_i.nclk;
        calc.tdi_levels  = op_i.data & mask;
        calc.tms_levels  = hold8 & mask;
        calc.reply_byte  = op_i.rd ? low_reply : 8'd0;
      end
      jsce_pkg::OP_BIT_MSB: begin
        calc.clock_count = op_i.nclk;
        calc.tdi_levels  = jsce_pkg::rev8(op_i.data) & mask;
        calc.tms_levels  = hold8 & mask;
        calc.reply_valid = 1'b0;
      end
      jsce_pkg::OP_TMS: begin
        calc.clock_count = op_i.nclk;
        calc.tdi_levels  = op_i.data[7] ? mask : 8'd0;
        calc.tms_levels  = op_i.data & mask;
        calc.reply_byte  = op_i.rd ? low_reply : 8'd0;
      end
      default: begin
        calc.reply_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_d       = res_q;
    valid_d     = valid_q;
    echo_d      = echo_q;
    echo_byte_d = echo_byte_q;
    if (load) begin
      if (echo_q) begin
        res_d             = '0;
        res_d.reply_valid = 1'b1;
        res_d.reply_byte  = echo_byte_q;
        res_d.last        = 1'b1;
        valid_d           = 1'b1;
        echo_d            = 1'b0;
      end else if (op_valid_i) begin
        res_d   = calc;
        valid_d = 1'b1;
        if (op_i.kind == jsce_pkg::OP_ERROR) begin
          echo_d      = 1'b1;
          echo_byte_d = op_i.data;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      echo_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      echo_q  <= echo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    echo_byte_q <= echo_byte_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/core/jtag_shift_command_engine.sv
// top level of the jtag shift command engine: front parser, op queue and shift back end
// depends on jsce_pkg, jsce_front, jsce_fifo and jsce_back
//
// One host byte enters per cycle while s_axis_tready_o is high, together with the TDO
// samples of its clocks. Argument, length and no-op bytes give no result; shift and reply
// bytes give one result, and an unknown command gives two (0xFA, then the echoed byte).
// Each result is registered first in the op queue and then in the output register.
// The engine sustains one byte per cycle while the output side keeps taking results,
// except that the back end takes no new op from the queue while the echoed byte of an
// unknown command is pending; s_axis_tready_o drops only while the
// FifoDepth-entry op queue is full.
module jtag_shift_command_engine #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] stream_byte, [15:8] tdo_samples
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [3:0] clock_count, [11:4] tdi_levels,
                                       // [19:12] tms_levels, [27:20] reply_byte, rest zero
  output logic        m_axis_tuser_o,  // reply_valid
  output logic        m_axis_tlast_o
);

  logic              accept, push, full, op_valid, pop;
  jsce_pkg::op_t     op_in, op_out;
  jsce_pkg::result_t res;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  jsce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .stream_byte_i (s_axis_tdata_i[7:0]),
    .tdo_samples_i (s_axis_tdata_i[15:8]),
    .push_o        (push),
    .op_o          (op_in)
  );

  jsce_fifo #(
    .Width (jsce_pkg::OpW),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (op_out),
    .valid_o (op_valid)
  );

  jsce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op_out),
    .op_pop_o    (pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {4'd0, res.reply_byte, res.tms_levels, res.tdi_levels,
                           res.clock_count};
  assign m_axis_tuser_o = res.reply_valid;
  assign m_axis_tlast_o = res.last;

endmodule
